FILE: rtl/masked_byte_pattern_scan_macros.svh
// Assertion macros for the masked byte pattern scanner.
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define MBPS_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scanner invariant violated");
// Check a condition in the cycle after a trigger.
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner next-cycle check violated");
`else
`define MBPS_ASSERT_HOLDS(lbl, expr)
`define MBPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/mbps_pkg.sv
// Shared constants and types of the masked byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none
package mbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int CELL_IDX_W  = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 6;

  typedef logic [MAX_PATTERN-1:0][7:0] mbps_pat_t;

  typedef enum logic [2:0] {
    REG_PAT_LOW,
    REG_PAT_MID_LOW,
    REG_PAT_MID_HIGH,
    REG_PAT_HIGH,
    REG_CARE,
    REG_LENGTH,
    REG_REGION_BASE,
    REG_LOAD_BASE
  } mbps_reg_t;

  // One matching window start, handed to the address pipeline.
  typedef struct packed {
    logic        valid;
    logic [31:0] offset;
  } mbps_hit_t;

endpackage
`default_nettype wire

FILE: rtl/masked_byte_pattern_scan.sv
// Top level of the masked byte pattern scanner.
//
// Usage:
//   Bytes of a region arrive on the input channel (in_valid / in_ready,
//   data_byte, last_in_region), one beat per byte in address order. Set
//   last_in_region on the final byte; the window and byte count clear after it.
//   Each beat whose newest pattern_length bytes match the pattern (care bit
//   clear = wildcard) yields one result beat on the output channel
//   (out_valid / out_ready, match_relative, match_absolute).
//   Throughput: one byte per cycle while in_ready is high, as the cell chain
//   shifts and compares each accepted byte. A matching byte's result passes
//   through the compare/offset, relative add and absolute add registers
//   before out_valid rises.
//   Configuration: wr_en / wr_index / wr_data write one register per cycle;
//   write only while no results are in flight.
//   Reset (rst, synchronous): registers take their reset values (length 1),
//   window cells and byte count clear, the address pipeline empties. No
//   clearing pass is needed.
//   Receiver stall: the three result stages fill up first; in_ready drops only
//   when every stage holds a result and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_byte_pattern_scan_macros.svh"
module masked_byte_pattern_scan (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_in_region,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] match_relative,
  output logic [63:0] match_absolute
);
  import mbps_pkg::*;

  // Configuration registers.
  logic [3:0][63:0]       pattern_words;
  logic [MAX_PATTERN-1:0] care_bits;
  logic [LEN_W-1:0]       pattern_length;
  logic [31:0]            region_base;
  logic [63:0]            load_base;

  // Scan state.
  logic [31:0]      bytes_seen;
  logic [31:0]      seen_next;
  logic [LEN_W-1:0] len_eff;
  logic             accept;
  logic             miss;
  mbps_pat_t        pattern;
  mbps_hit_t        hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      care_bits      <= '0;
      pattern_length <= LEN_W'(1);
      region_base    <= '0;
      load_base      <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAT_LOW:      pattern_words[0] <= wr_data;
        REG_PAT_MID_LOW:  pattern_words[1] <= wr_data;
        REG_PAT_MID_HIGH: pattern_words[2] <= wr_data;
        REG_PAT_HIGH:     pattern_words[3] <= wr_data;
        REG_CARE:         care_bits        <= wr_data[MAX_PATTERN-1:0];
        REG_LENGTH:       pattern_length   <= wr_data[LEN_W-1:0];
        REG_REGION_BASE:  region_base      <= wr_data[31:0];
        REG_LOAD_BASE:    load_base        <= wr_data;
        default:          ;
      endcase
    end
  end

  // Byte 0 of the low word is pattern byte 0; packing keeps that order.
  assign pattern = pattern_words;

  // Lengths beyond the window act as a full window.
  assign len_eff = (pattern_length > LEN_W'(MAX_PATTERN)) ?
                   LEN_W'(MAX_PATTERN) : pattern_length;

  assign accept    = in_valid && in_ready;
  assign seen_next = bytes_seen + 32'd1;

  // Count bytes of the current region; drop the count after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (accept) begin
      bytes_seen <= last_in_region ? 32'd0 : seen_next;
    end
  end

  mbps_window u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (accept),
    .clear     (last_in_region),
    .data_byte (data_byte),
    .pattern   (pattern),
    .care      (care_bits),
    .len_eff   (len_eff),
    .miss      (miss)
  );

  // A match needs a nonzero length, a full window and no cared-for mismatch.
  assign hit.valid  = accept && (len_eff != '0) && (seen_next >= 32'(len_eff)) && !miss;
  assign hit.offset = seen_next - 32'(len_eff);

  mbps_addr_pipe u_addr_pipe (
    .clk            (clk),
    .rst            (rst),
    .hit            (hit),
    .region_base    (region_base),
    .load_base      (load_base),
    .ready          (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_relative (match_relative),
    .match_absolute (match_absolute)
  );

  // Input backpressure only comes from a full pipeline behind a stalled sink.
  `MBPS_ASSERT_HOLDS(a_ready_only_when_full, in_ready || (out_valid && !out_ready))
  // The byte count restarts after a region's last byte.
  `MBPS_ASSERT_NEXT(a_count_clears, accept && last_in_region, bytes_seen == 32'd0)
  // The absolute address tracks the relative one on every result.
  `MBPS_ASSERT_HOLDS(a_abs_matches_rel,
    !out_valid || (match_absolute == load_base + 64'(match_relative)))

endmodule
`default_nettype wire

FILE: rtl/mbps_cell.sv
// One window cell: holds a byte, passes it on, and checks its incoming byte.
`timescale 1ns / 1ps
`default_nettype none
module mbps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] din,
  input  logic       check,
  input  logic [7:0] expect_byte,
  output logic [7:0] dout,
  output logic       miss
);

  // Compare the value this cell takes on the current beat.
  assign miss = check && (din != expect_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= 8'd0;
    end else if (shift) begin
      dout <= clear ? 8'd0 : din;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mbps_window.sv
// Shift window of cells with per-cell pattern selection and mismatch reduction.
`timescale 1ns / 1ps
`default_nettype none
module mbps_window (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic                    clear,
  input  logic [7:0]              data_byte,
  input  mbps_pkg::mbps_pat_t     pattern,
  input  logic [mbps_pkg::MAX_PATTERN-1:0] care,
  input  logic [mbps_pkg::LEN_W-1:0]       len_eff,
  output logic                    miss
);
  import mbps_pkg::*;

  logic [MAX_PATTERN-1:0][7:0] cell_q;
  logic [MAX_PATTERN-1:0]      cell_miss;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    localparam logic [LEN_W-1:0] K = LEN_W'(k);
    logic [7:0]            din;
    logic [LEN_W-1:0]      pidx_full;
    logic [CELL_IDX_W-1:0] pidx;
    logic                  active;

    // Cell k holds window byte k; it lines up with pattern byte len-1-k.
    assign din       = (k == 0) ? data_byte : cell_q[(k == 0) ? 0 : k - 1];
    assign active    = K < len_eff;
    assign pidx_full = len_eff - K - LEN_W'(1);
    assign pidx      = pidx_full[CELL_IDX_W-1:0];

    mbps_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (shift),
      .clear       (clear),
      .din         (din),
      .check       (active && care[pidx]),
      .expect_byte (pattern[pidx]),
      .dout        (cell_q[k]),
      .miss        (cell_miss[k])
    );
  end

  assign miss = |cell_miss;

endmodule
`default_nettype wire

FILE: rtl/mbps_addr_pipe.sv
// Match address pipeline: offset, relative address, absolute address.
`timescale 1ns / 1ps
`default_nettype none
module mbps_addr_pipe (
  input  logic                clk,
  input  logic                rst,
  input  mbps_pkg::mbps_hit_t hit,
  input  logic [31:0]         region_base,
  input  logic [63:0]         load_base,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         match_relative,
  output logic [63:0]         match_absolute
);
  import mbps_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_offset;
  logic        s2_valid;
  logic [31:0] s2_rel;
  logic        s3_ok;
  logic        s2_ok;

  // Each stage moves on when the one after it is empty or moving.
  assign s3_ok = !out_valid || out_ready;
  assign s2_ok = !s2_valid || s3_ok;
  assign ready = !s1_valid || s2_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= hit.valid;
      end
      if (s2_ok) begin
        s2_valid <= s1_valid;
      end
      if (s3_ok) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && hit.valid) begin
      s1_offset <= hit.offset;
    end
    if (s2_ok && s1_valid) begin
      s2_rel <= region_base + s1_offset;
    end
    if (s3_ok && s2_valid) begin
      match_relative <= s2_rel;
      match_absolute <= load_base + 64'(s2_rel);
    end
  end

endmodule
`default_nettype wire

FILE: test/tb_masked_byte_pattern_scan.sv
// Self-checking testbench for the masked byte pattern scanner.
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;
  import mbps_pkg::*;

  // Results trail their byte by three stages; allow slack before a register write.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no beat on either channel and no write before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1450;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] rel;
    logic [63:0] abs;
  } match_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        wr_en          = 1'b0;
  logic [2:0]  wr_index       = '0;
  logic [63:0] wr_data        = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte      = '0;
  logic        last_in_region = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] match_relative;
  logic [63:0] match_absolute;

  // Shadow copy of the configuration registers.
  logic [255:0] cfg_pat         = '0;
  logic [31:0]  cfg_care        = '0;
  logic [5:0]   cfg_len         = 6'd1;
  logic [31:0]  cfg_region_base = '0;
  logic [63:0]  cfg_load_base   = '0;

  // Shadow copy of the scan state: cell 0 holds the newest byte.
  logic [7:0]   scan_window [MAX_PATTERN];
  logic [31:0]  region_count  = '0;

  byte_beat_t   pending_beats [$];
  match_t       expected_matches [$];
  match_t       got_match;
  int           mismatch_count = 0;
  int           items_queued   = 0;
  int           quiet_cycles   = 0;
  bit           steady_run     = 1'b0;

  masked_byte_pattern_scan u_top (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_in_region (last_in_region),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_relative (match_relative),
    .match_absolute (match_absolute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Length in use: zero disables matching, anything past the window depth clamps to it.
  function automatic int effective_length();
    return (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
  endfunction

  // Advance the shadow window by one accepted byte and queue the match it completes.
  function automatic void predict_match(logic [7:0] b, logic last);
    int     len;
    logic   hit;
    match_t m;
    len = effective_length();
    for (int k = MAX_PATTERN - 1; k > 0; k--) begin
      scan_window[k] = scan_window[k - 1];
    end
    scan_window[0] = b;
    region_count   = region_count + 32'd1;
    hit = (len != 0) && (region_count >= 32'(len));
    // Window byte j counts from the oldest; care bits past the length never matter.
    for (int j = 0; j < len; j++) begin
      if (cfg_care[j] && scan_window[len - 1 - j] != cfg_pat[j*8 +: 8]) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      m.rel = cfg_region_base + (region_count - 32'(len));
      m.abs = cfg_load_base + {32'h0, m.rel};
      expected_matches = {expected_matches, m};
    end
    // Clear after the flagged byte, so a match ending on it still counts.
    if (last) begin
      scan_window  = '{default: 8'h00};
      region_count = '0;
    end
  endfunction

  // Queue one byte beat; the driver below presents it when its turn comes.
  task automatic send_byte(logic [7:0] b, logic last);
    byte_beat_t beat;
    beat.data = b;
    beat.last = last;
    pending_beats = {pending_beats, beat};
    items_queued++;
  endtask

  // Hold the sender until every queued beat is taken and every match is back.
  task automatic wait_for_matches();
    do @(posedge clk); while (pending_beats.size() != 0 || expected_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call at a clock edge with the block idle; the spare cycle keeps wr_en edges apart.
  task automatic write_reg(mbps_reg_t idx, logic [63:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH: begin
        cfg_pat[int'(idx)*64 +: 64] = value;
      end
      REG_CARE:        cfg_care        = value[31:0];
      REG_LENGTH:      cfg_len         = value[5:0];
      REG_REGION_BASE: cfg_region_base = value[31:0];
      REG_LOAD_BASE:   cfg_load_base   = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(logic [255:0] pat, logic [31:0] care, logic [5:0] len,
                             logic [31:0] rbase, logic [63:0] lbase);
    write_reg(REG_PAT_LOW,      pat[63:0]);
    write_reg(REG_PAT_MID_LOW,  pat[127:64]);
    write_reg(REG_PAT_MID_HIGH, pat[191:128]);
    write_reg(REG_PAT_HIGH,     pat[255:192]);
    write_reg(REG_CARE,         {32'h0, care});
    write_reg(REG_LENGTH,       {58'h0, len});
    write_reg(REG_REGION_BASE,  {32'h0, rbase});
    write_reg(REG_LOAD_BASE,    lbase);
  endtask

  // Build one region of n bytes; a well-formed one carries the pattern at random starts,
  // with random bytes in the wildcard slots.
  task automatic send_region(int n, bit well_formed);
    logic [7:0] bytes_q [$];
    int         len;
    int         start;
    len = effective_length();
    for (int i = 0; i < n; i++) begin
      bytes_q = {bytes_q, 8'($urandom)};
    end
    if (well_formed && len > 0 && n >= len) begin
      repeat ($urandom_range(1, 3)) begin
        start = $urandom_range(0, n - len);
        for (int j = 0; j < len; j++) begin
          if (cfg_care[j]) begin
            bytes_q[start + j] = cfg_pat[j*8 +: 8];
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      send_byte(bytes_q[i], i == n - 1);
    end
  endtask

  // Input driver: hold a beat until taken, then present the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_match(data_byte, last_in_region);
        void'(pending_beats.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && (steady_run || $urandom_range(0, 99) >= 23)) begin
          in_valid       <= 1'b1;
          data_byte      <= pending_beats[0].data;
          last_in_region <= pending_beats[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall about a quarter of the time except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady_run || ($urandom_range(0, 99) >= 23);
  end

  // Compare each result beat with the oldest expected match, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected match rel=%h abs=%h",
                                  match_relative, match_absolute));
      end else begin
        got_match = expected_matches.pop_front();
        if (match_relative !== got_match.rel) begin
          report_mismatch($sformatf("match_relative %h, want %h",
                                    match_relative, got_match.rel));
        end
        if (match_absolute !== got_match.abs) begin
          report_mismatch($sformatf("match_absolute %h, want %h",
                                    match_absolute, got_match.abs));
        end
      end
    end
  end

  // Watchdog: drop the run when neither channel nor the write port has moved for too long.
  always @(posedge clk) begin
    if (rst || wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_masked_byte_pattern_scan: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset values: length 1 with no care bits matches every byte.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_for_matches();
  endtask

  // Full compare of four bytes, match ending on the flagged byte, absolute add wrapping.
  task automatic test_exact_pattern();
    load_config({224'h0, 32'hEFBE_ADDE}, 32'h0000_000F, 6'd4,
                32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h11, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b1);
    wait_for_matches();
  endtask

  // Middle byte is a wildcard; care bits and pattern bytes past the length are junk.
  task automatic test_wildcards();
    load_config({{29{8'hA5}}, 8'hFF, 8'h77, 8'h00}, 32'hFFFF_FFF5, 6'd3, 32'h0, 64'h0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_for_matches();
  endtask

  // A region shorter than the pattern gives nothing and must not leak into the next.
  task automatic test_short_region();
    load_config({216'h0, 40'h05_0403_0201}, 32'hFFFF_FFFF, 6'd5, 32'h1000, 64'h8000_0000);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    for (int i = 1; i <= 5; i++) begin
      send_byte(8'(i), i == 5);
    end
    wait_for_matches();
  endtask

  // Zero length never matches, even with every byte a wildcard.
  task automatic test_zero_length();
    load_config('0, 32'h0, 6'd0, 32'h0, 64'h0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_for_matches();
  endtask

  // Length past the window depth clamps to the full 32-byte compare.
  task automatic test_length_overflow();
    logic [255:0] pat;
    pat = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    load_config(pat, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 64'h1);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      send_byte(pat[j*8 +: 8], j == MAX_PATTERN - 1);
    end
    wait_for_matches();
  endtask

  // Random phases: fresh configuration, mostly well-formed regions, some noise.
  task automatic test_random_regions(int target);
    logic [255:0] pat;
    logic [31:0]  care;
    logic [5:0]   len;
    logic [31:0]  rbase;
    logic [63:0]  lbase;
    int           pick;
    int           n;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       len = 6'd0;
      else if (pick < 12) len = 6'($urandom_range(33, 63));
      else if (pick < 22) len = 6'd32;
      else                len = 6'($urandom_range(1, 8));
      pick = $urandom_range(0, 99);
      if (pick < 20)      care = 32'hFFFF_FFFF;
      else if (pick < 30) care = 32'h0;
      else                care = $urandom;
      pat = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 20)      rbase = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      else if (pick < 30) rbase = 32'h0;
      else                rbase = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 20)      lbase = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      else if (pick < 30) lbase = 64'h0;
      else                lbase = {$urandom, $urandom};
      load_config(pat, care, len, rbase, lbase);
      // Run a long stretch with neither side idling.
      steady_run = (items_queued >= 600 && items_queued < 900);
      repeat ($urandom_range(3, 12)) begin
        // Stop adding regions once the item budget is spent.
        if (items_queued < target) begin
          n = $urandom_range(1, 2 * effective_length() + 8);
          send_region(n, $urandom_range(0, 99) < 75);
          // Now and then pause the sender mid-phase until all matches are back.
          if ($urandom_range(0, 99) < 8) begin
            wait_for_matches();
          end
        end
      end
      wait_for_matches();
    end
    steady_run = 1'b0;
  endtask

  initial begin
    scan_window = '{default: 8'h00};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_exact_pattern();
    test_wildcards();
    test_short_region();
    test_zero_length();
    test_length_overflow();
    test_random_regions(items_queued + RANDOM_ITEMS);
    wait_for_matches();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_matches.size() != 0) begin
      report_mismatch("expected match never arrived");
    end
    if (mismatch_count == 0) begin
      $display("tb_masked_byte_pattern_scan: done, clean");
    end else begin
      $display("tb_masked_byte_pattern_scan: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_window.sv
rtl/mbps_addr_pipe.sv
rtl/masked_byte_pattern_scan.sv
test/tb_masked_byte_pattern_scan.sv
